// ===== rtl/core/bfts_pkg.sv =====
// Shared constants, types and control structs for the brute-force tour search.
// No dependencies; every other file of the block imports this package.
package bfts_pkg;

   localparam int MAX_CITIES  = 8;
   localparam int CITY_W      = $clog2(MAX_CITIES);
   localparam int COUNT_W     = 4;
   localparam int LENGTH_BITS = 16;
   localparam int TOUR_W      = 19;
   localparam int DIST_ADDR_W = 2 * CITY_W;
   localparam int DIST_DEPTH  = MAX_CITIES * MAX_CITIES;
   localparam int PADDR_W     = 3;
   localparam int PDATA_W     = 32;

   localparam logic [TOUR_W-1:0]  TOUR_MAX  = {TOUR_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CITIES);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic REG_CITY_COUNT = 1'b0;
   localparam logic REG_START_CITY = 1'b1;

   typedef logic [CITY_W-1:0]      city_type;
   typedef logic [TOUR_W-1:0]      tour_type;
   typedef logic [LENGTH_BITS-1:0] length_type;

   typedef struct packed {
      logic clear;
      logic add;
      logic judge;
      logic fresh;
   } tour_ctl_type;

   typedef struct packed {
      logic     better;
      tour_type best;
   } tour_sts_type;

endpackage

// ===== rtl/core/bfts_if.sv =====
// Valid/ready channel interfaces for search requests and route results.
// Depends on bfts_pkg.
interface bfts_req_if import bfts_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       cmd;
   city_type   from_city;
   city_type   to_city;
   length_type edge_length;

   modport source (output valid, cmd, from_city, to_city, edge_length, input ready);
   modport sink   (input valid, cmd, from_city, to_city, edge_length, output ready);
endinterface

interface bfts_rsp_if import bfts_pkg::*; ();
   logic     valid;
   logic     ready;
   city_type route_city;
   tour_type tour_length;
   logic     last;

   modport source (output valid, route_city, tour_length, last, input ready);
   modport sink   (input valid, route_city, tour_length, last, output ready);
endinterface

// ===== rtl/core/bfts_dist_ram.sv =====
// Distance memory: one write port, one read port with registered read data.
// Depends on bfts_pkg.
module bfts_dist_ram import bfts_pkg::*; (
   input  logic                   clock,
   input  logic                   we,
   input  logic [DIST_ADDR_W-1:0] waddr,
   input  length_type             wdata,
   input  logic                   re,
   input  logic [DIST_ADDR_W-1:0] raddr,
   output length_type             rdata
);

   length_type mem [DIST_DEPTH];
   length_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/bfts_perm_step.sv =====
// Lexicographic next-permutation step over the first m entries of the order.
// Depends on bfts_pkg.
module bfts_perm_step import bfts_pkg::*; (
   input  city_type            a   [MAX_CITIES],
   input  logic [CITY_W-1:0]   m,
   output city_type            nxt [MAX_CITIES],
   output logic                has_next
);

   city_type piv;
   city_type sw;
   city_type pval;
   city_type b [MAX_CITIES];

   always_comb begin
      piv      = '0;
      has_next = 1'b0;
      for (int x = 1; x < MAX_CITIES; x++) begin
         if (x < int'(m) && a[x-1] < a[x]) begin
            piv      = CITY_W'(x);
            has_next = 1'b1;
         end
      end
      pval = a[piv - 1'b1];
      sw   = piv;
      for (int y = 0; y < MAX_CITIES; y++) begin
         if (y >= int'(piv) && y < int'(m) && a[y] > pval) begin
            sw = CITY_W'(y);
         end
      end
      b = a;
      if (has_next) begin
         b[piv - 1'b1] = a[sw];
         b[sw]         = pval;
      end
      for (int x = 0; x < MAX_CITIES; x++) begin
         if (x >= int'(piv) && x < int'(m)) begin
            nxt[x] = b[CITY_W'(int'(piv) + int'(m) - 1 - x)];
         end else begin
            nxt[x] = b[x];
         end
      end
   end

endmodule

// ===== rtl/core/bfts_tour_unit.sv =====
// Shared saturating accumulator and best-length compare for tour sums.
// Depends on bfts_pkg.
module bfts_tour_unit import bfts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  tour_ctl_type ctl,
   input  length_type   edge_len,
   output tour_sts_type sts
);

   tour_type          acc_ff, acc_in;
   tour_type          best_ff, best_in;
   logic [TOUR_W:0]   sum;
   logic              better;

   always_comb begin
      sum    = {1'b0, acc_ff} + (TOUR_W+1)'(edge_len);
      better = ctl.judge && (ctl.fresh || acc_ff < best_ff);
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.add) begin
         acc_in = (sum > {1'b0, TOUR_MAX}) ? TOUR_MAX : sum[TOUR_W-1:0];
      end
      best_in = better ? acc_ff : best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         best_ff <= TOUR_MAX;
      end else begin
         acc_ff  <= acc_in;
         best_ff <= best_in;
      end
   end

   assign sts.better = better;
   assign sts.best   = best_ff;

endmodule

// ===== rtl/core/brute_force_tour_search.sv =====
// Brute-force closed-tour search: top level with sequencer, CSR port and result channel.
// Depends on bfts_pkg, bfts_if, bfts_dist_ram, bfts_perm_step and bfts_tour_unit.
//
// A load transfer (cmd 0) writes one distance entry. A search transfer (cmd 1) with n
// cities walks all (n-1)! orders of the other cities; for each order the single read
// port of the distance memory feeds one edge per cycle into the shared saturating
// adder, followed by the drain and compare states. The n route results then leave one
// per cycle while rsp.ready is high. The block takes no request from search start
// until the last result transfer.
module brute_force_tour_search import bfts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   bfts_req_if.sink           req,
   bfts_rsp_if.source         rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SUM   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_JUDGE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   city_count_ff, city_count_in;
   city_type             start_city_ff, start_city_in;
   logic [COUNT_W-1:0]   n_ff, n_in;
   city_type             s_ff, s_in;
   city_type             m_ff, m_in;
   city_type             e_ff, e_in;
   city_type             k_ff, k_in;
   logic                 pend_ff, pend_in;
   logic                 fresh_ff, fresh_in;
   city_type             order_ff [MAX_CITIES];
   city_type             order_in [MAX_CITIES];
   city_type             best_order_ff [MAX_CITIES];
   city_type             best_order_in [MAX_CITIES];
   city_type             init_order [MAX_CITIES];
   city_type             next_order [MAX_CITIES];
   logic                 has_next;
   logic [COUNT_W-1:0]   n_clamp;
   logic                 csr_wr;
   logic                 req_xfer;
   logic                 rsp_xfer;
   city_type             from_sel, to_sel;
   length_type           edge_len;
   tour_ctl_type         tour_ctl;
   tour_sts_type         tour_sts;

   bfts_dist_ram u_dist_ram (
      .clock (clock),
      .we    (req_xfer && req.cmd == CMD_LOAD),
      .waddr ({req.from_city, req.to_city}),
      .wdata (req.edge_length),
      .re    (state_ff == ST_SUM),
      .raddr ({from_sel, to_sel}),
      .rdata (edge_len)
   );

   bfts_perm_step u_perm_step (
      .a        (order_ff),
      .m        (m_ff),
      .nxt      (next_order),
      .has_next (has_next)
   );

   bfts_tour_unit u_tour_unit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tour_ctl),
      .edge_len (edge_len),
      .sts      (tour_sts)
   );

   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite && pready;
   assign prdata   = (paddr[2] == REG_START_CITY) ? PDATA_W'(start_city_ff)
                                                  : PDATA_W'(city_count_ff);
   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign rsp_xfer  = rsp.valid && rsp.ready;

   assign from_sel = (e_ff == '0) ? s_ff : order_ff[e_ff - 1'b1];
   assign to_sel   = (e_ff == m_ff) ? s_ff : order_ff[e_ff];

   assign rsp.valid       = (state_ff == ST_EMIT);
   assign rsp.route_city  = (k_ff == '0) ? s_ff : best_order_ff[k_ff - 1'b1];
   assign rsp.tour_length = tour_sts.best;
   assign rsp.last        = ({1'b0, k_ff} == n_ff - 1'b1);

   always_comb begin
      tour_ctl.clear = (req_xfer && req.cmd == CMD_SEARCH) ||
                       (state_ff == ST_JUDGE && has_next);
      tour_ctl.add   = pend_ff;
      tour_ctl.judge = (state_ff == ST_JUDGE);
      tour_ctl.fresh = fresh_ff;
   end

   always_comb begin
      if (city_count_ff < COUNT_MIN) begin
         n_clamp = COUNT_MIN;
      end else if (city_count_ff > COUNT_MAX) begin
         n_clamp = COUNT_MAX;
      end else begin
         n_clamp = city_count_ff;
      end
      for (int k = 0; k < MAX_CITIES; k++) begin
         init_order[k] = (k < int'(start_city_ff)) ? CITY_W'(k) : CITY_W'(k + 1);
      end
   end

   always_comb begin
      city_count_in = city_count_ff;
      start_city_in = start_city_ff;
      if (csr_wr) begin
         if (paddr[2] == REG_CITY_COUNT) begin
            city_count_in = pwdata[COUNT_W-1:0];
         end else begin
            start_city_in = pwdata[CITY_W-1:0];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      s_in          = s_ff;
      m_in          = m_ff;
      e_in          = e_ff;
      k_in          = k_ff;
      pend_in       = (state_ff == ST_SUM);
      fresh_in      = fresh_ff;
      order_in      = order_ff;
      best_order_in = best_order_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req.cmd == CMD_SEARCH) begin
               n_in     = n_clamp;
               s_in     = start_city_ff;
               m_in     = CITY_W'(n_clamp - 1'b1);
               e_in     = '0;
               fresh_in = 1'b1;
               order_in = init_order;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (e_ff == m_ff) begin
               state_in = ST_DRAIN;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            if (tour_sts.better) begin
               best_order_in = order_ff;
            end
            fresh_in = 1'b0;
            order_in = next_order;
            e_in     = '0;
            k_in     = '0;
            state_in = has_next ? ST_SUM : ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (rsp.last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         city_count_ff <= COUNT_MIN;
         start_city_ff <= '0;
         pend_ff       <= 1'b0;
         fresh_ff      <= 1'b0;
         e_ff          <= '0;
         k_ff          <= '0;
         for (int i = 0; i < MAX_CITIES; i++) begin
            order_ff[i]      <= '0;
            best_order_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         city_count_ff <= city_count_in;
         start_city_ff <= start_city_in;
         pend_ff       <= pend_in;
         fresh_ff      <= fresh_in;
         e_ff          <= e_in;
         k_ff          <= k_in;
         order_ff      <= order_in;
         best_order_ff <= best_order_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      s_ff <= s_in;
      m_ff <= m_in;
   end

   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request side ready while route results are pending");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last) |=> req.ready)
      else $error("block not idle after final route transfer");

   a_judge_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_JUDGE) |-> !pend_ff)
      else $error("tour compared before its last edge was added");

endmodule
